[rtl/line_follow_pid_steering_top_defines.svh]
// Assertion macros for the steering top level.
`ifndef LINE_FOLLOW_PID_STEERING_TOP_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFPS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/lfps_pkg.sv]
// Types, constants and the position encoder for the steering block.
`default_nettype none
package lfps_pkg;

    localparam int SENS_W   = 7;
    localparam int POS_W    = 5;     // 2*rear + front, -9..9
    localparam int ERR_W    = 13;
    localparam int SUM_W    = 32;
    localparam int DERIV_W  = 14;
    localparam int GAIN_W   = 22;
    localparam int OFFS_W   = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;
    localparam int P_W      = GAIN_W + 1 + ERR_W;    // 36
    localparam int I_W      = GAIN_W + 1 + SUM_W;    // 55
    localparam int D_W      = GAIN_W + 1 + DERIV_W;  // 37
    localparam int ACC_W    = I_W + 2;
    localparam int CLIP_W   = 25;    // holds +-255.0 in Q9.16
    localparam int FRAC_W   = 16;
    localparam int DUTY_W   = 8;
    localparam int DRIVE_W  = 9;

    localparam logic signed [OFFS_W-1:0] OFFSET_RST = 12'sd300;
    localparam logic [GAIN_W-1:0] KP_RST = 22'd6554;
    localparam logic [GAIN_W-1:0] KI_RST = 22'd3;
    localparam logic [GAIN_W-1:0] KD_RST = 22'd65536;

    localparam logic signed [ERR_W-1:0] ERR_MAX = 13'sd4095;
    localparam logic signed [ERR_W-1:0] ERR_MIN = -13'sd4096;
    localparam logic [DUTY_W-1:0] DUTY_FULL = 8'hff;

    // Register map of the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TARGET_OFFSET = 2'd0,
        REG_PROP_GAIN     = 2'd1,
        REG_INTEG_GAIN    = 2'd2,
        REG_DERIV_GAIN    = 2'd3
    } lfps_reg_idx_t;

    typedef struct packed {
        logic signed [OFFS_W-1:0] target_offset;
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        integ_gain;
        logic [GAIN_W-1:0]        deriv_gain;
    } lfps_cfg_t;

    // Error-stage word handed to the multipliers
    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   sum;
        logic signed [DERIV_W-1:0] deriv;
    } lfps_err_t;

    // Registered PID products
    typedef struct packed {
        logic signed [P_W-1:0] p_term;
        logic signed [I_W-1:0] i_term;
        logic signed [D_W-1:0] d_term;
    } lfps_prod_t;

    // Board priority encoder: center first, then outer to inner pairs
    function automatic logic signed [2:0] board_position(input logic [SENS_W-1:0] s);
        logic signed [2:0] p;
        if (s[3])      p = 3'sd0;
        else if (s[0]) p = 3'sd3;
        else if (s[6]) p = -3'sd3;
        else if (s[1]) p = 3'sd2;
        else if (s[5]) p = -3'sd2;
        else if (s[2]) p = 3'sd1;
        else if (s[4]) p = -3'sd1;
        else           p = 3'sd0;
        return p;
    endfunction

endpackage
`default_nettype wire

[rtl/lfps_if.sv]
// Handshake interfaces for sensor, steering and configuration channels.
`default_nettype none
interface lfps_sens_if;
    logic                       valid;
    logic                       ready;
    logic [lfps_pkg::SENS_W-1:0] front_sensors;
    logic [lfps_pkg::SENS_W-1:0] rear_sensors;
    modport source (output valid, front_sensors, rear_sensors, input ready);
    modport sink   (input valid, front_sensors, rear_sensors, output ready);
endinterface

interface lfps_steer_if;
    logic                               valid;
    logic                               ready;
    logic [lfps_pkg::DUTY_W-1:0]        left_duty;
    logic [lfps_pkg::DUTY_W-1:0]        right_duty;
    logic                               left_brake;
    logic                               right_brake;
    logic signed [lfps_pkg::DRIVE_W-1:0] drive_value;
    modport source (output valid, left_duty, right_duty, left_brake, right_brake,
                    drive_value, input ready);
    modport sink   (input valid, left_duty, right_duty, left_brake, right_brake,
                    drive_value, output ready);
endinterface

interface lfps_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lfps_pkg::CFG_IDX_W-1:0]  index;
    logic [lfps_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[rtl/line_follow_pid_steering_top.sv]
// Line-follow PID steering: top level with pipeline control and checks.
//
// Channels: sens takes one word per control tick (front and rear 7-bit
// sensor patterns), steer returns one word per sensor word (left/right duty,
// brakes, signed drive value), cfg writes the offset and three Q6.16 gains; cfg
// is always ready; the user must write it only while the block is idle (unenforced).
// Pipeline: sensor register, error/integral stage, product register,
// result register. Throughput is one word per cycle unless the receiver
// stalls, since the integral is updated once for every accepted word.
// All four stages advance together whenever the result register is empty
// or being taken, so a stalled receiver holds every stage and drops
// sens.ready in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits, the integral sum and the previous error, and
// loads the default offset (300) and gains (0.1, 0.00005, 1.0).
`default_nettype none
`include "line_follow_pid_steering_top_defines.svh"
module line_follow_pid_steering_top #(
    parameter int POSITION_SCALE = 100
) (
    input  wire logic clk,
    input  wire logic rst_n,
    lfps_sens_if.sink     sens,
    lfps_steer_if.source  steer,
    lfps_cfg_if.sink      cfg
);
    import lfps_pkg::*;

    lfps_cfg_t  cfg_regs;
    lfps_err_t  err_word;
    lfps_prod_t prod_word;
    logic       err_valid;
    logic       prod_valid;
    logic       advance;

    // Whole pipeline moves when the result slot frees up
    assign advance    = !steer.valid || steer.ready;
    assign sens.ready = advance;

    lfps_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .cfg_regs (cfg_regs)
    );

    lfps_err_stage #(
        .POSITION_SCALE (POSITION_SCALE)
    ) u_err (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (sens.valid),
        .front_sensors (sens.front_sensors),
        .rear_sensors  (sens.rear_sensors),
        .target_offset (cfg_regs.target_offset),
        .err_valid     (err_valid),
        .err_word      (err_word)
    );

    lfps_mult_stage u_mult (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .err_valid  (err_valid),
        .err_word   (err_word),
        .cfg_regs   (cfg_regs),
        .prod_valid (prod_valid),
        .prod_word  (prod_word)
    );

    lfps_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .prod_valid (prod_valid),
        .prod_word  (prod_word),
        .steer      (steer)
    );

    // Checks
    `LFPS_ASSERT_IMPL(a_one_side_slowed, clk, rst_n, steer.valid,
        (steer.left_duty == DUTY_FULL) || (steer.right_duty == DUTY_FULL),
        "both duties reduced at once")
    `LFPS_ASSERT_IMPL(a_drive_matches_duty, clk, rst_n, steer.valid && (steer.drive_value >= 0),
        (9'(steer.left_duty) + steer.drive_value[DUTY_W-1:0] == 9'(DUTY_FULL)),
        "left duty does not match positive drive")
    `LFPS_ASSERT_IMPL(a_stall_blocks_input, clk, rst_n, steer.valid && !steer.ready,
        !sens.ready, "input accepted while result is stalled")
    `LFPS_ASSERT_NEXT(a_stall_holds_integral, clk, rst_n, !advance,
        $stable(err_word.sum) && $stable(prod_valid),
        "pipeline moved during a stall")
endmodule
`default_nettype wire

[rtl/lfps_cfg_regs.sv]
// Configuration register file: offset and the three PID gains.
`default_nettype none
module lfps_cfg_regs (
    input  wire logic           clk,
    input  wire logic           rst_n,
    lfps_cfg_if.sink            cfg,
    output lfps_pkg::lfps_cfg_t cfg_regs
);
    import lfps_pkg::*;

    lfps_cfg_t cfg_reg;
    lfps_cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_regs  = cfg_reg;

    // Decode one write word
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (lfps_reg_idx_t'(cfg.index))
                REG_TARGET_OFFSET: cfg_next.target_offset = $signed(cfg.data[OFFS_W-1:0]);
                REG_PROP_GAIN:     cfg_next.prop_gain     = cfg.data[GAIN_W-1:0];
                REG_INTEG_GAIN:    cfg_next.integ_gain    = cfg.data[GAIN_W-1:0];
                REG_DERIV_GAIN:    cfg_next.deriv_gain    = cfg.data[GAIN_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.target_offset <= OFFSET_RST;
            cfg_reg.prop_gain     <= KP_RST;
            cfg_reg.integ_gain    <= KI_RST;
            cfg_reg.deriv_gain    <= KD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule
`default_nettype wire

[rtl/lfps_err_stage.sv]
// Sensor register, position encode, error, integral and derivative state.
`default_nettype none
module lfps_err_stage #(
    parameter int POSITION_SCALE = 100
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           advance,
    input  wire logic                           in_valid,
    input  wire logic [lfps_pkg::SENS_W-1:0]    front_sensors,
    input  wire logic [lfps_pkg::SENS_W-1:0]    rear_sensors,
    input  wire logic signed [lfps_pkg::OFFS_W-1:0] target_offset,
    output logic                                err_valid,
    output lfps_pkg::lfps_err_t                 err_word
);
    import lfps_pkg::*;

    // Width of pos*scale - offset before clamping
    localparam int RAW_W = $clog2(9 * POSITION_SCALE + 2049) + 1;
    localparam logic signed [RAW_W-1:0] SCALE_S = RAW_W'(POSITION_SCALE);
    localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(ERR_MAX);
    localparam logic signed [RAW_W-1:0] RAW_MIN = RAW_W'(ERR_MIN);

    logic              sens_valid_reg;
    logic [SENS_W-1:0] front_reg;
    logic [SENS_W-1:0] rear_reg;
    logic              err_valid_reg;
    lfps_err_t         err_word_reg;
    lfps_err_t         err_word_next;
    logic signed [SUM_W-1:0] error_sum_reg;
    logic signed [SUM_W-1:0] error_sum_next;
    logic signed [ERR_W-1:0] last_error_reg;

    logic signed [2:0]       front_pos;
    logic signed [2:0]       rear_pos;
    logic signed [POS_W-1:0] pos;
    logic signed [RAW_W-1:0] raw_err;
    logic signed [ERR_W-1:0] err;
    logic signed [SUM_W:0]   sum_wide;
    logic                    step;

    assign step = advance && sens_valid_reg;

    // Position and clamped error
    always_comb
    begin
        front_pos = board_position(front_reg);
        rear_pos  = board_position(rear_reg);
        pos = $signed({rear_pos[2], rear_pos, 1'b0}) + $signed({{2{front_pos[2]}}, front_pos});
        raw_err = RAW_W'(pos) * SCALE_S - RAW_W'(target_offset);
        if (raw_err > RAW_MAX)
            err = ERR_MAX;
        else if (raw_err < RAW_MIN)
            err = ERR_MIN;
        else
            err = raw_err[ERR_W-1:0];
    end

    // Saturating integral; zero error leaves it alone
    always_comb
    begin
        sum_wide = (SUM_W+1)'(error_sum_reg) + (SUM_W+1)'(err);
        if (err == '0)
            error_sum_next = error_sum_reg;
        else if (sum_wide[SUM_W] != sum_wide[SUM_W-1])
            error_sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                             : {1'b0, {(SUM_W-1){1'b1}}};
        else
            error_sum_next = sum_wide[SUM_W-1:0];
        err_word_next.err   = err;
        err_word_next.sum   = error_sum_next;
        err_word_next.deriv = DERIV_W'(err) - DERIV_W'(last_error_reg);
    end

    // Valid bits and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_valid_reg <= 1'b0;
            err_valid_reg  <= 1'b0;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
        end
        else if (advance)
        begin
            sens_valid_reg <= in_valid;
            err_valid_reg  <= sens_valid_reg;
            if (step)
            begin
                error_sum_reg  <= error_sum_next;
                last_error_reg <= err;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            front_reg    <= front_sensors;
            rear_reg     <= rear_sensors;
            err_word_reg <= err_word_next;
        end
    end

    assign err_valid = err_valid_reg;
    assign err_word  = err_word_reg;
endmodule
`default_nettype wire

[rtl/lfps_mult_stage.sv]
// Three parallel gain multipliers with a registered result.
`default_nettype none
module lfps_mult_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 err_valid,
    input  wire lfps_pkg::lfps_err_t  err_word,
    input  wire lfps_pkg::lfps_cfg_t  cfg_regs,
    output logic                      prod_valid,
    output lfps_pkg::lfps_prod_t      prod_word
);
    import lfps_pkg::*;

    logic       prod_valid_reg;
    lfps_prod_t prod_reg;
    lfps_prod_t prod_next;

    // Gains are unsigned: a zero bit keeps them positive
    always_comb
    begin
        prod_next.p_term = P_W'($signed({1'b0, cfg_regs.prop_gain})) * P_W'(err_word.err);
        prod_next.i_term = I_W'($signed({1'b0, cfg_regs.integ_gain})) * I_W'(err_word.sum);
        prod_next.d_term = D_W'($signed({1'b0, cfg_regs.deriv_gain})) * D_W'(err_word.deriv);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prod_valid_reg <= 1'b0;
        else if (advance)
            prod_valid_reg <= err_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            prod_reg <= prod_next;
    end

    assign prod_valid = prod_valid_reg;
    assign prod_word  = prod_reg;
endmodule
`default_nettype wire

[rtl/lfps_out_stage.sv]
// PID sum, output clamp, truncation and duty/brake result register.
`default_nettype none
module lfps_out_stage (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic                 prod_valid,
    input  wire lfps_pkg::lfps_prod_t prod_word,
    lfps_steer_if.source              steer
);
    import lfps_pkg::*;

    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(255 * 65536);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(255 * 65536);

    logic signed [ACC_W-1:0]   acc;
    logic signed [CLIP_W-1:0]  acc_clip;
    logic signed [DRIVE_W-1:0] drive_floor;
    logic signed [DRIVE_W-1:0] drive;
    logic [DUTY_W-1:0]         mag;
    logic [DUTY_W-1:0]         ldu;
    logic [DUTY_W-1:0]         rdu;

    logic                      valid_reg;
    logic [DUTY_W-1:0]         ldu_reg;
    logic [DUTY_W-1:0]         rdu_reg;
    logic signed [DRIVE_W-1:0] drive_reg;

    // Sum and clamp to +-255.0
    always_comb
    begin
        acc = ACC_W'(prod_word.p_term) + ACC_W'(prod_word.i_term) + ACC_W'(prod_word.d_term);
        if (acc > LIM_POS)
            acc_clip = CLIP_W'(LIM_POS);
        else if (acc < LIM_NEG)
            acc_clip = CLIP_W'(LIM_NEG);
        else
            acc_clip = acc[CLIP_W-1:0];
    end

    // Truncate toward zero: floor, plus one for negative with a fraction
    always_comb
    begin
        drive_floor = acc_clip[CLIP_W-1:FRAC_W];
        if (acc_clip[CLIP_W-1] && (acc_clip[FRAC_W-1:0] != '0))
            drive = drive_floor + DRIVE_W'(1);
        else
            drive = drive_floor;
    end

    // Positive drive slows the left side, negative the right
    always_comb
    begin
        mag = drive[DRIVE_W-1] ? DUTY_W'(-drive) : drive[DUTY_W-1:0];
        ldu = DUTY_FULL;
        rdu = DUTY_FULL;
        if (drive > 0)
            ldu = DUTY_FULL - mag;
        else if (drive < 0)
            rdu = DUTY_FULL - mag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (advance)
            valid_reg <= prod_valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ldu_reg   <= ldu;
            rdu_reg   <= rdu;
            drive_reg <= drive;
        end
    end

    assign steer.valid       = valid_reg;
    assign steer.left_duty   = ldu_reg;
    assign steer.right_duty  = rdu_reg;
    assign steer.left_brake  = (ldu_reg == '0);
    assign steer.right_brake = (rdu_reg == '0);
    assign steer.drive_value = drive_reg;
endmodule
`default_nettype wire

[sim/tb_line_follow_pid_steering_top.sv]
// Self-checking testbench for the line-follow PID steering block.
module tb_line_follow_pid_steering_top;
    import lfps_pkg::*;

    localparam int POSITION_SCALE = 100;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BURST_MAX      = 12;
    localparam int PHASE_WORDS    = 140;
    localparam int PHASE_COUNT    = 6;
    localparam int GROWTH_WORDS   = 24;
    localparam longint DRIVE_LIMIT_Q16 = 64'sd255 * 64'sd65536;

    // One steering word as seen on the result channel
    typedef struct packed {
        logic [DUTY_W-1:0]         left_duty;
        logic [DUTY_W-1:0]         right_duty;
        logic                      left_brake;
        logic                      right_brake;
        logic signed [DRIVE_W-1:0] drive_value;
    } steer_word_t;

    logic clk;
    logic rst_n;

    lfps_sens_if  sens_if ();
    lfps_steer_if steer_if ();
    lfps_cfg_if   cfg_if ();

    line_follow_pid_steering_top #(
        .POSITION_SCALE (POSITION_SCALE)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .sens  (sens_if),
        .steer (steer_if),
        .cfg   (cfg_if)
    );

    // Shadow of the controller: settings, integral sum, previous error
    int     offset_q;
    longint prop_gain_q;
    longint integ_gain_q;
    longint deriv_gain_q;
    int     error_sum_q;
    int     last_error_q;

    steer_word_t pending_steer[$];
    int          fail_count  = 0;
    int          idle_cycles = 0;
    bit          idle_enable = 1'b1;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Board encoder: center wins, then outer, middle and inner pairs
    function automatic int encode_board(input logic [SENS_W-1:0] s);
        if (s[3]) return 0;
        if (s[0]) return 3;
        if (s[6]) return -3;
        if (s[1]) return 2;
        if (s[5]) return -2;
        if (s[2]) return 1;
        if (s[4]) return -1;
        return 0;
    endfunction

    // Steering word for one sensor word; advances the shadow state
    function automatic steer_word_t predict_steer(input logic [SENS_W-1:0] front,
                                                  input logic [SENS_W-1:0] rear);
        int          pos;
        longint      err;
        longint      sum;
        longint      acc;
        longint      drive;
        steer_word_t w;
        pos = 2 * encode_board(rear) + encode_board(front);
        err = longint'(pos) * POSITION_SCALE - offset_q;
        if (err > 4095) err = 4095;
        if (err < -4096) err = -4096;
        // integrate only nonzero errors, saturating at 32 bits
        if (err != 0)
        begin
            sum = longint'(error_sum_q) + err;
            if (sum > 64'sd2147483647) sum = 64'sd2147483647;
            if (sum < -64'sd2147483648) sum = -64'sd2147483648;
            error_sum_q = int'(sum);
        end
        acc = prop_gain_q * err + integ_gain_q * error_sum_q
            + deriv_gain_q * (err - last_error_q);
        if (acc > DRIVE_LIMIT_Q16) acc = DRIVE_LIMIT_Q16;
        if (acc < -DRIVE_LIMIT_Q16) acc = -DRIVE_LIMIT_Q16;
        drive = acc / 65536;    // truncates toward zero
        last_error_q = int'(err);
        w.left_duty  = 8'd255;
        w.right_duty = 8'd255;
        if (drive > 0)
            w.left_duty = 8'(255 - drive);
        else if (drive < 0)
            w.right_duty = 8'(255 + drive);
        w.left_brake  = (w.left_duty == 8'd0);
        w.right_brake = (w.right_duty == 8'd0);
        w.drive_value = drive[DRIVE_W-1:0];
        return w;
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 100)
            $display("%0t mismatch: %s", $time, msg);
    endtask

    // Track config writes, predict on sensor words, check steering words
    always @(negedge clk)
    begin
        steer_word_t got;
        steer_word_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (cfg_if.valid && cfg_if.ready)
            begin
                idle_cycles = 0;
                case (cfg_if.index)
                    REG_TARGET_OFFSET: offset_q = int'($signed(cfg_if.data[OFFS_W-1:0]));
                    REG_PROP_GAIN:     prop_gain_q  = longint'(cfg_if.data);
                    REG_INTEG_GAIN:    integ_gain_q = longint'(cfg_if.data);
                    REG_DERIV_GAIN:    deriv_gain_q = longint'(cfg_if.data);
                    default: ;
                endcase
            end
            if (sens_if.valid && sens_if.ready)
            begin
                idle_cycles = 0;
                pending_steer.push_back(predict_steer(sens_if.front_sensors,
                                                      sens_if.rear_sensors));
            end
            if (steer_if.valid && steer_if.ready)
            begin
                idle_cycles = 0;
                got.left_duty   = steer_if.left_duty;
                got.right_duty  = steer_if.right_duty;
                got.left_brake  = steer_if.left_brake;
                got.right_brake = steer_if.right_brake;
                got.drive_value = steer_if.drive_value;
                if (pending_steer.size() == 0)
                    report_mismatch($sformatf("steering word with none pending, drive %0d",
                                              got.drive_value));
                else
                begin
                    want = pending_steer.pop_front();
                    if (got.left_duty !== want.left_duty)
                        report_mismatch($sformatf("left_duty %0d, want %0d",
                                                  got.left_duty, want.left_duty));
                    if (got.right_duty !== want.right_duty)
                        report_mismatch($sformatf("right_duty %0d, want %0d",
                                                  got.right_duty, want.right_duty));
                    if (got.left_brake !== want.left_brake)
                        report_mismatch($sformatf("left_brake %0b, want %0b",
                                                  got.left_brake, want.left_brake));
                    if (got.right_brake !== want.right_brake)
                        report_mismatch($sformatf("right_brake %0b, want %0b",
                                                  got.right_brake, want.right_brake));
                    if (got.drive_value !== want.drive_value)
                        report_mismatch($sformatf("drive_value %0d, want %0d",
                                                  got.drive_value, want.drive_value));
                end
            end
        end
    end

    // Watchdog: too long with no word moving on any channel
    initial
    begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: ready drops in random bursts while idling is on
    initial
    begin
        steer_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 7) == 0)
            begin
                steer_if.ready <= 1'b0;
                repeat ($urandom_range(1, BURST_MAX)) @(posedge clk);
            end
            steer_if.ready <= 1'b1;
        end
    end

    // Send one sensor word; returns at the edge that takes it
    task automatic send_reading(input logic [SENS_W-1:0] front,
                                input logic [SENS_W-1:0] rear);
        int gap;
        if (idle_enable && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, BURST_MAX);
            sens_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sens_if.valid         <= 1'b1;
        sens_if.front_sensors <= front;
        sens_if.rear_sensors  <= rear;
        @(negedge clk);
        while (!sens_if.ready) @(negedge clk);
        @(posedge clk);
    endtask

    // Config write; valid stays high so writes can go back to back
    task automatic write_register(input lfps_reg_idx_t idx,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        @(negedge clk);
        while (!cfg_if.ready) @(negedge clk);
        @(posedge clk);
    endtask

    // Drain the pipeline, then load all four registers
    task automatic apply_settings(input logic [OFFS_W-1:0] offset,
                                  input logic [GAIN_W-1:0] kp,
                                  input logic [GAIN_W-1:0] ki,
                                  input logic [GAIN_W-1:0] kd);
        sens_if.valid <= 1'b0;
        while (pending_steer.size() != 0) @(posedge clk);
        write_register(REG_TARGET_OFFSET, CFG_DATA_W'(offset));
        write_register(REG_PROP_GAIN, kp);
        write_register(REG_INTEG_GAIN, ki);
        write_register(REG_DERIV_GAIN, kd);
        cfg_if.valid <= 1'b0;
    endtask

    // Mostly small gains, sometimes the full range or an extreme
    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 3))
            0:       return GAIN_W'($urandom_range(0, 2000));
            1:       return GAIN_W'($urandom_range(0, 262144));
            2:       return GAIN_W'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
        endcase
    endfunction

    // Plausible board reading: one sensor, two neighbors, center plus one, or lost line
    function automatic logic [SENS_W-1:0] line_pattern();
        int k;
        k = $urandom_range(0, SENS_W - 1);
        case ($urandom_range(0, 3))
            0:       return SENS_W'(1) << k;
            1:       return (k < SENS_W - 1) ? SENS_W'(3) << k : SENS_W'(1) << k;
            2:       return SENS_W'(8) | (SENS_W'(1) << k);
            default: return '0;
        endcase
    endfunction

    // Encoder corners under reset settings
    task automatic test_board_encoding();
        // nothing lit, everything lit
        send_reading(7'h00, 7'h00);
        send_reading(7'h7f, 7'h7f);
        // each sensor alone, mirrored between boards
        for (int i = 0; i < SENS_W; i++)
            send_reading(SENS_W'(1) << i, SENS_W'(1) << (SENS_W - 1 - i));
        // outer over middle over inner, center over everything
        send_reading(7'h41, 7'h41);
        send_reading(7'h22, 7'h22);
        send_reading(7'h14, 7'h14);
        send_reading(7'h49, 7'h1c);
        send_reading(7'h50, 7'h30);
    endtask

    // Full swings clip the drive and brake one side; zero error holds the sum
    task automatic test_drive_limits();
        send_reading(7'h40, 7'h40);
        send_reading(7'h01, 7'h01);
        send_reading(7'h40, 7'h40);
        send_reading(7'h01, 7'h00);
        send_reading(7'h01, 7'h00);
    endtask

    // Several register settings, extremes first, random sensor traffic
    task automatic test_random_settings();
        logic [OFFS_W-1:0] offs;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0:
                begin
                    offs = 12'h7ff;
                    kp = '1;
                    ki = '1;
                    kd = '1;
                end
                1:
                begin
                    offs = 12'h800;
                    kp = '0;
                    ki = '0;
                    kd = '0;
                end
                2:
                begin
                    offs = '0;
                    kp = 22'd6554;
                    ki = 22'd3;
                    kd = 22'd65536;
                end
                default:
                begin
                    offs = OFFS_W'($urandom);
                    kp = pick_gain();
                    ki = pick_gain();
                    kd = pick_gain();
                end
            endcase
            apply_settings(offs, kp, ki, kd);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (n % 25 == 0)
                    idle_enable = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) < 7)
                    send_reading(line_pattern(), line_pattern());
                else
                    send_reading(SENS_W'($urandom), SENS_W'($urandom));
            end
        end
    endtask

    // Largest positive error every tick with integral gain only: drive ramps up
    task automatic test_integral_growth();
        idle_enable = 1'b0;
        apply_settings(12'h800, '0, 22'd16, '0);
        repeat (GROWTH_WORDS) send_reading(7'h01, 7'h01);
        repeat (16) send_reading(SENS_W'($urandom), SENS_W'($urandom));
    endtask

    // Sequence
    initial
    begin
        rst_n                 = 1'b0;
        sens_if.valid         = 1'b0;
        sens_if.front_sensors = '0;
        sens_if.rear_sensors  = '0;
        cfg_if.valid          = 1'b0;
        cfg_if.index          = '0;
        cfg_if.data           = '0;
        offset_q              = 300;
        prop_gain_q           = 6554;
        integ_gain_q          = 3;
        deriv_gain_q          = 65536;
        error_sum_q           = 0;
        last_error_q          = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_board_encoding();
        test_drive_limits();
        test_random_settings();
        test_integral_growth();

        // let the pipeline empty, then watch for stray words
        sens_if.valid <= 1'b0;
        while (pending_steer.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_steer.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/lfps_pkg.sv
rtl/lfps_if.sv
rtl/lfps_cfg_regs.sv
rtl/lfps_err_stage.sv
rtl/lfps_mult_stage.sv
rtl/lfps_out_stage.sv
rtl/line_follow_pid_steering_top.sv
sim/tb_line_follow_pid_steering_top.sv
